@@ hdl/mec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pkg: shared types, constants and helpers
// Fixed-point formats, register indexes, reset values, sequencer states,
// saturation and coordinate clamping for the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int COORD_W   = 11;
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 28;
  localparam int PROD_W    = 2 * Q_W;
  localparam int SQ_W      = PROD_W - 1 - FRAC_BITS;  // squares are never negative
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_FRAC_LEFT = 3'd0;
  localparam cfg_idx_t REG_FRAC_TOP  = 3'd1;
  localparam cfg_idx_t REG_X_STEP    = 3'd2;
  localparam cfg_idx_t REG_Y_STEP    = 3'd3;
  localparam cfg_idx_t REG_MAX_ITER  = 3'd4;

  localparam q_t   RST_FRAC_LEFT = -32'sd536870912;
  localparam q_t   RST_FRAC_TOP  = -32'sd268435456;
  localparam q_t   RST_X_STEP    = 32'sd262144;
  localparam q_t   RST_Y_STEP    = 32'sd262144;
  localparam cnt_t RST_MAX_ITER  = 16'd256;

  // 4.0 in the format of a sum of two shifted squares
  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

  localparam prod_t Q_MAX = 64'sd2147483647;
  localparam prod_t Q_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR,
    S_CI,
    S_RR,
    S_II,
    S_RI,
    S_UPD,
    S_DONE
  } state_t;

  function automatic q_t sat_q(input prod_t v);
    if (v > Q_MAX) begin
      return q_t'(Q_MAX);
    end else if (v < Q_MIN) begin
      return q_t'(Q_MIN);
    end else begin
      return q_t'(v);
    end
  endfunction

  function automatic coord_t clamp_coord(input coord_t v);
    if (32'(v) > MAX_DIM - 1) begin
      return COORD_W'(MAX_DIM - 1);
    end else begin
      return v;
    end
  endfunction

endpackage

@@ hdl/mandelbrot_escape_count.sv @@
// a new item is taken only in the idle state, after the previous result has been written to the result register
// each iteration forms zr*zr, zi*zi and zr*zi in turn on the one shared 32 x 32 multiplier
// reset (synchronous, active low) restores register defaults and empties the block
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_count: fixed-point escape-time counter
// Maps a pixel to c in Q4.28, iterates z = z*z + c from zero and returns
// the number of steps before |z|^2 reaches 4 or the limit is hit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mec_pkg::coord_t       in_column,
  input  mec_pkg::coord_t       in_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mec_pkg::cnt_t         out_iteration_count,
  input  logic                  cfg_wr_en,
  input  mec_pkg::cfg_idx_t     cfg_index,
  input  logic [31:0]           cfg_data
);
  import mec_pkg::*;

  state_t state_r, state_nxt;
  q_t     frac_left_r, frac_top_r, x_step_r, y_step_r;
  cnt_t   max_iter_r;
  coord_t row_r, row_nxt;
  q_t     cr_r, cr_nxt, ci_r, ci_nxt;
  q_t     zr_r, zr_nxt, zi_r, zi_nxt;
  sq_t    sr_r, sr_nxt, si_r, si_nxt;
  cnt_t   n_r, n_nxt;
  logic   out_valid_r, out_valid_nxt;
  cnt_t   out_count_r, out_count_nxt;

  q_t     mul_a, mul_b;
  prod_t  prod_r;
  sq_t    sq_cur;
  logic   escaped;
  prod_t  nr_wide, ni_wide, c_wide_r, c_wide_i;

  mec_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  // squares are non-negative, so the dropped sign bit is always zero
  assign sq_cur  = prod_r[PROD_W-2:FRAC_BITS];
  assign escaped = ({1'b0, sr_r} + {1'b0, sq_cur} >= ESC_LIMIT) || (n_r >= max_iter_r);

  assign c_wide_r = prod_r + prod_t'(frac_left_r);
  assign c_wide_i = prod_r + prod_t'(frac_top_r);
  assign nr_wide  = $signed({{(PROD_W-SQ_W){1'b0}}, sr_r})
                  - $signed({{(PROD_W-SQ_W){1'b0}}, si_r}) + prod_t'(cr_r);
  // floor of twice the cross product shifted by the fraction width
  assign ni_wide  = (prod_r >>> (FRAC_BITS - 1)) + prod_t'(ci_r);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    mul_a         = zr_r;
    mul_b         = zr_r;
    case (state_r)
      S_IDLE: begin
        mul_a = $signed({{(Q_W-COORD_W){1'b0}}, clamp_coord(in_column)});
        mul_b = x_step_r;
        if (in_valid) begin
          row_nxt   = clamp_coord(in_row);
          state_nxt = S_CR;
        end
      end
      S_CR: begin
        cr_nxt    = sat_q(c_wide_r);
        mul_a     = $signed({{(Q_W-COORD_W){1'b0}}, row_r});
        mul_b     = y_step_r;
        state_nxt = S_CI;
      end
      S_CI: begin
        ci_nxt    = sat_q(c_wide_i);
        zr_nxt    = '0;
        zi_nxt    = '0;
        n_nxt     = '0;
        state_nxt = S_RR;
      end
      S_RR: begin
        state_nxt = S_II;
      end
      S_II: begin
        sr_nxt    = sq_cur;
        mul_a     = zi_r;
        mul_b     = zi_r;
        state_nxt = S_RI;
      end
      S_RI: begin
        si_nxt = sq_cur;
        mul_a  = zr_r;
        mul_b  = zi_r;
        if (escaped) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        zr_nxt    = sat_q(nr_wide);
        zi_nxt    = sat_q(ni_wide);
        n_nxt     = n_r + cnt_t'(1);
        state_nxt = S_RR;
      end
      S_DONE: begin
        // wait for the result register to drain
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      frac_left_r <= RST_FRAC_LEFT;
      frac_top_r  <= RST_FRAC_TOP;
      x_step_r    <= RST_X_STEP;
      y_step_r    <= RST_Y_STEP;
      max_iter_r  <= RST_MAX_ITER;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAC_LEFT: frac_left_r <= q_t'(cfg_data);
          REG_FRAC_TOP:  frac_top_r  <= q_t'(cfg_data);
          REG_X_STEP:    x_step_r    <= q_t'(cfg_data);
          REG_Y_STEP:    y_step_r    <= q_t'(cfg_data);
          REG_MAX_ITER:  max_iter_r  <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    sr_r        <= sr_nxt;
    si_r        <= si_nxt;
    n_r         <= n_nxt;
    out_count_r <= out_count_nxt;
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= max_iter_r)
    else $error("result count above iteration limit");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RR || state_r == S_II || state_r == S_RI || state_r == S_UPD)
      |-> n_r <= max_iter_r)
    else $error("iteration counter ran past limit");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_CR)
    else $error("accepted item did not start the sequence");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without finishing an item");
`endif

endmodule

@@ hdl/mec_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_mul: shared signed multiplier
// One 32 x 32 signed multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module mec_mul (
  input  logic           clk,
  input  mec_pkg::q_t    op_a,
  input  mec_pkg::q_t    op_b,
  output mec_pkg::prod_t prod_r
);
  import mec_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= prod_t'(op_a) * prod_t'(op_b);
  end

endmodule
